### rtl/dhfk_pkg.sv
// package: widths, constants and arctan table for the 3r forward kinematics block
package dhfk_pkg;
   localparam int ANG_W        = 16;
   localparam int LEN_W        = 16;
   localparam int ROT_W        = 16;
   localparam int POS_W        = 20;
   localparam int CSR_IDX_W    = 3;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN    = 24;
   localparam int XW           = 34;
   localparam int ZW           = 28;

   localparam logic [CSR_IDX_W-1:0] REG_LINK1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LINK2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LINK3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFF1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFF2  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFF3  = 3'd5;

   localparam logic signed [ANG_W-1:0] PI_Q13      = 16'sd25735;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12867;
   localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
   localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_lane_type;

   typedef struct packed {
      logic                       err;
      logic signed [LEN_W-1:0]    a1, a2, a3, d1, d2, d3;
   } ctx_type;

   function automatic logic signed [ZW-1:0] atan_q24(input int i);
      logic signed [ZW-1:0] t;
      case (i)
         0: t = 28'sd13176795;  1: t = 28'sd7778716;  2: t = 28'sd4110060;
         3: t = 28'sd2086331;   4: t = 28'sd1047214;  5: t = 28'sd524117;
         6: t = 28'sd262123;    7: t = 28'sd131069;
         default: t = (i < TABLE_LEN) ? ZW'(28'sd1 <<< (24 - i)) : '0;
      endcase
      return t;
   endfunction
endpackage

### rtl/dhfk_if.sv
// valid/ready channel interface carrying one word of payload
interface dhfk_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/dhfk_cordic_cell.sv
// one cordic micro-rotation cell for three lanes, registered
module dhfk_cordic_cell #(parameter int STEP = 0) (
   input  logic clock,
   input  logic enable,
   input  dhfk_pkg::cordic_lane_type lane_in  [3],
   output dhfk_pkg::cordic_lane_type lane_out [3]
);
   import dhfk_pkg::*;
   cordic_lane_type lane_ff [3];
   cordic_lane_type lane_in_v [3];
   localparam logic signed [ZW-1:0] AT = atan_q24(STEP);
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (!lane_in[l].z[ZW-1]) begin
            lane_in_v[l].x = lane_in[l].x - (lane_in[l].y >>> STEP);
            lane_in_v[l].y = lane_in[l].y + (lane_in[l].x >>> STEP);
            lane_in_v[l].z = lane_in[l].z - AT;
         end else begin
            lane_in_v[l].x = lane_in[l].x + (lane_in[l].y >>> STEP);
            lane_in_v[l].y = lane_in[l].y - (lane_in[l].x >>> STEP);
            lane_in_v[l].z = lane_in[l].z + AT;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (enable) lane_ff <= lane_in_v;
   end
   assign lane_out = lane_ff;
endmodule

### rtl/dhfk_compose.sv
// transform build and matrix product over four stages, emitting one row per cycle while rsp is ready
module dhfk_compose (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  dhfk_pkg::ctx_type ctx,
   input  logic signed [dhfk_pkg::ROT_W-1:0] cs [3],
   input  logic signed [dhfk_pkg::ROT_W-1:0] sn [3],
   dhfk_if.source rsp
);
   import dhfk_pkg::*;
   // stage p: sine and cosine words held
   logic                    p_v_ff;
   ctx_type                 p_ctx_ff;
   logic signed [ROT_W-1:0] p_cs_ff [3];
   logic signed [ROT_W-1:0] p_sn_ff [3];
   // stage q: link position terms a*cos and a*sin (q22)
   logic                    q_v_ff;
   logic                    q_err_ff;
   logic signed [ROT_W-1:0] q_cs_ff [3];
   logic signed [ROT_W-1:0] q_sn_ff [3];
   logic signed [31:0]      q_ac_ff [3];
   logic signed [31:0]      q_as_ff [3];
   logic signed [LEN_W-1:0] q_d_ff [3];
   // stage a: compose m1*m2 (rotation q28, position q36)
   logic                    a_v_ff;
   logic                    a_err_ff;
   logic signed [31:0]      r12_ff [3][3];
   logic signed [47:0]      p12_ff [3];
   logic signed [ROT_W-1:0] c3_ff, s3_ff;
   logic signed [31:0]      ac3_ff, as3_ff;
   logic signed [LEN_W-1:0] d3_ff;
   // stage b: final per-row values, held until three rows go out, or one error word
   logic                    b_v_ff;
   logic [1:0]              row_ff;
   logic                    b_err_ff;
   logic signed [ROT_W-1:0] rot_ff [3][3];
   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [ROT_W-1:0] m1r [3][3];
   logic signed [ROT_W-1:0] m2r [3][3];
   logic signed [31:0]      m1p [3], m2p [3];
   logic signed [ROT_W-1:0] rot_in [3][3];
   logic signed [POS_W-1:0] pos_in [3];
   logic p_adv, q_adv, a_adv, b_load, b_done;
   logic signed [ROT_W-1:0] m3r [3][3];
   logic signed [31:0]      m3p [3];

   assign b_done = b_v_ff && rsp.ready && (b_err_ff || row_ff == 2'd2);
   assign b_load = a_v_ff && (!b_v_ff || b_done);
   assign a_adv  = !a_v_ff || b_load;
   assign q_adv  = !q_v_ff || a_adv;
   assign p_adv  = !p_v_ff || q_adv;
   assign in_ready = p_adv;

   always_ff @(posedge clock) begin
      if (reset) p_v_ff <= 1'b0;
      else if (p_adv) p_v_ff <= in_valid;
      if (p_adv) begin
         p_ctx_ff <= ctx;
         p_cs_ff <= cs;
         p_sn_ff <= sn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_v_ff <= 1'b0;
      else if (q_adv) q_v_ff <= p_v_ff;
      if (q_adv) begin
         q_err_ff <= p_ctx_ff.err;
         q_cs_ff <= p_cs_ff;
         q_sn_ff <= p_sn_ff;
         q_ac_ff[0] <= 32'(p_ctx_ff.a1) * 32'(p_cs_ff[0]);
         q_as_ff[0] <= 32'(p_ctx_ff.a1) * 32'(p_sn_ff[0]);
         q_ac_ff[1] <= 32'(p_ctx_ff.a2) * 32'(p_cs_ff[1]);
         q_as_ff[1] <= 32'(p_ctx_ff.a2) * 32'(p_sn_ff[1]);
         q_ac_ff[2] <= 32'(p_ctx_ff.a3) * 32'(p_cs_ff[2]);
         q_as_ff[2] <= 32'(p_ctx_ff.a3) * 32'(p_sn_ff[2]);
         q_d_ff[0] <= p_ctx_ff.d1;
         q_d_ff[1] <= p_ctx_ff.d2;
         q_d_ff[2] <= p_ctx_ff.d3;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            m1r[i][j] = '0; m2r[i][j] = '0;
         end
      m1r[0][0] = q_cs_ff[0]; m1r[1][0] = q_sn_ff[0];
      m1r[0][2] = q_sn_ff[0]; m1r[1][2] = -q_cs_ff[0]; m1r[2][1] = 16'sd16384;
      m1p[0] = q_ac_ff[0]; m1p[1] = q_as_ff[0];
      m1p[2] = 32'(q_d_ff[0]) <<< 14;
      m2r[0][0] = q_cs_ff[1]; m2r[1][0] = q_sn_ff[1];
      m2r[0][1] = -q_sn_ff[1]; m2r[1][1] = q_cs_ff[1]; m2r[2][2] = 16'sd16384;
      m2p[0] = q_ac_ff[1]; m2p[1] = q_as_ff[1];
      m2p[2] = 32'(q_d_ff[1]) <<< 14;
   end

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (a_adv) a_v_ff <= q_v_ff;
      if (a_adv) begin
         a_err_ff <= q_err_ff;
         c3_ff <= q_cs_ff[2]; s3_ff <= q_sn_ff[2];
         ac3_ff <= q_ac_ff[2]; as3_ff <= q_as_ff[2]; d3_ff <= q_d_ff[2];
         for (int i = 0; i < 3; i++) begin
            p12_ff[i] <= (48'(m1p[i]) <<< 14) + 48'(m1r[i][0]) * 48'(m2p[0])
                         + 48'(m1r[i][1]) * 48'(m2p[1]) + 48'(m1r[i][2]) * 48'(m2p[2]);
            for (int j = 0; j < 3; j++)
               r12_ff[i][j] <= 32'(m1r[i][0]) * 32'(m2r[0][j])
                               + 32'(m1r[i][1]) * 32'(m2r[1][j])
                               + 32'(m1r[i][2]) * 32'(m2r[2][j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) m3r[i][j] = '0;
      m3r[0][0] = c3_ff; m3r[1][0] = s3_ff;
      m3r[0][1] = -s3_ff; m3r[1][1] = c3_ff; m3r[2][2] = 16'sd16384;
      m3p[0] = ac3_ff; m3p[1] = as3_ff;
      m3p[2] = 32'(d3_ff) <<< 14;
      for (int i = 0; i < 3; i++) begin
         logic signed [63:0] acc;
         logic signed [63:0] rr;
         acc = (64'(p12_ff[i]) <<< 14) + 64'(r12_ff[i][0]) * 64'(m3p[0])
               + 64'(r12_ff[i][1]) * 64'(m3p[1]) + 64'(r12_ff[i][2]) * 64'(m3p[2]);
         acc = (acc + (64'sd1 <<< 41)) >>> 42;
         pos_in[i] = (acc > 64'sd524287) ? 20'sd524287 :
                     (acc < -64'sd524288) ? -20'sd524288 : POS_W'(acc);
         for (int j = 0; j < 3; j++) begin
            rr = 64'(r12_ff[i][0]) * 64'(m3r[0][j]) + 64'(r12_ff[i][1]) * 64'(m3r[1][j])
                 + 64'(r12_ff[i][2]) * 64'(m3r[2][j]);
            rr = (rr + (64'sd1 <<< 27)) >>> 28;
            rot_in[i][j] = (rr > 64'sd16384) ? 16'sd16384 :
                           (rr < -64'sd16384) ? -16'sd16384 : ROT_W'(rr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
         row_ff <= 2'd0;
      end else if (b_load) begin
         b_v_ff <= 1'b1;
         row_ff <= 2'd0;
      end else if (b_done) begin
         b_v_ff <= 1'b0;
      end else if (b_v_ff && rsp.ready) begin
         row_ff <= row_ff + 2'd1;
      end
      if (b_load) begin
         b_err_ff <= a_err_ff;
         rot_ff <= rot_in;
         pos_ff <= pos_in;
      end
   end

   assign rsp.valid = b_v_ff;
   always_comb begin
      rsp.data = '0;
      rsp.data.angle_error = b_err_ff;
      rsp.data.last_row = b_err_ff || row_ff == 2'd2;
      if (!b_err_ff) begin
         rsp.data.row_index = row_ff;
         rsp.data.rot_col0 = rot_ff[row_ff][0];
         rsp.data.rot_col1 = rot_ff[row_ff][1];
         rsp.data.rot_col2 = rot_ff[row_ff][2];
         rsp.data.position = pos_ff[row_ff];
      end
   end
endmodule

### rtl/dh_forward_kinematics_3r.sv
// top level: range check, chain of cordic cells, transform product
//  channel | dir | payload
//  req     | in  | joint1_angle, joint2_angle, joint3_angle (q3.13)
//  rsp     | out | row_index, rot_col0..2, position, angle_error, last_row
//  csr     | in  | csr_write_enable, csr_index, csr_write_data
// an item enters each cycle the chain moves; the first row word is offered once the request has
// passed the CORDIC_STEPS cells (capped at 24) and compose stages p, q, a, b; the other two rows follow
// the chain takes new items while earlier ones are in flight; output pace is set by the three result words per item
// a held rsp fills the four compose stages, then the whole cordic chain stalls together
// synchronous reset clears valid flags and restores the register defaults
module dh_forward_kinematics_3r #(parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF) (
   input  logic clock,
   input  logic reset,
   dhfk_if.sink   req,
   dhfk_if.source rsp,
   input  logic                           csr_write_enable,
   input  logic [dhfk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dhfk_pkg::LEN_W-1:0]     csr_write_data
);
   import dhfk_pkg::*;
   localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   logic signed [LEN_W-1:0] reg_ff [6];
   cordic_lane_type lane [NS+1][3];
   logic            v_ff [NS+1];
   ctx_type         ctx_ff [NS+1];
   logic            neg_ff [NS+1][3];
   logic            adv;
   logic signed [ROT_W-1:0] cs [3], sn [3];
   logic signed [ANG_W-1:0] ang [3];
   logic c_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_ff[0] <= 16'sd2560; reg_ff[1] <= 16'sd1280; reg_ff[2] <= 16'sd1280;
         reg_ff[3] <= '0; reg_ff[4] <= '0; reg_ff[5] <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_LINK1: reg_ff[0] <= csr_write_data;
            REG_LINK2: reg_ff[1] <= csr_write_data;
            REG_LINK3: reg_ff[2] <= csr_write_data;
            REG_OFF1:  reg_ff[3] <= csr_write_data;
            REG_OFF2:  reg_ff[4] <= csr_write_data;
            REG_OFF3:  reg_ff[5] <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign adv = !v_ff[NS] || c_ready;
   assign req.ready = adv;
   assign ang[0] = req.data.joint1_angle;
   assign ang[1] = req.data.joint2_angle;
   assign ang[2] = req.data.joint3_angle;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         logic signed [ZW-1:0] z;
         z = ZW'(ang[l]) <<< 11;
         if (z > HALF_PI_Q24) begin
            lane[0][l].z = z - PI_Q24; neg_ff[0][l] = 1'b1;
         end else if (z < -HALF_PI_Q24) begin
            lane[0][l].z = z + PI_Q24; neg_ff[0][l] = 1'b1;
         end else begin
            lane[0][l].z = z; neg_ff[0][l] = 1'b0;
         end
         lane[0][l].x = GAIN_Q30;
         lane[0][l].y = '0;
      end
      v_ff[0] = req.valid;
      ctx_ff[0].err = ang[0] > PI_Q13 || ang[0] < -PI_Q13 || ang[1] > HALF_PI_Q13
                      || ang[1] < -HALF_PI_Q13 || ang[2] > PI_Q13 || ang[2] < -PI_Q13;
      ctx_ff[0].a1 = reg_ff[0]; ctx_ff[0].a2 = reg_ff[1]; ctx_ff[0].a3 = reg_ff[2];
      ctx_ff[0].d1 = reg_ff[3]; ctx_ff[0].d2 = reg_ff[4]; ctx_ff[0].d3 = reg_ff[5];
   end

   for (genvar s = 0; s < NS; s++) begin : g_cell
      dhfk_cordic_cell #(.STEP(s)) u_cell (
         .clock(clock), .enable(adv), .lane_in(lane[s]), .lane_out(lane[s+1]));
      always_ff @(posedge clock) begin
         if (reset) v_ff[s+1] <= 1'b0;
         else if (adv) v_ff[s+1] <= v_ff[s];
         if (adv) begin
            ctx_ff[s+1] <= ctx_ff[s];
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         logic signed [XW-1:0] x, y;
         x = neg_ff[NS][l] ? -lane[NS][l].x : lane[NS][l].x;
         y = neg_ff[NS][l] ? -lane[NS][l].y : lane[NS][l].y;
         x = (x + 34'sd32768) >>> 16;
         y = (y + 34'sd32768) >>> 16;
         cs[l] = (x > 34'sd16384) ? 16'sd16384 : (x < -34'sd16384) ? -16'sd16384 : ROT_W'(x);
         sn[l] = (y > 34'sd16384) ? 16'sd16384 : (y < -34'sd16384) ? -16'sd16384 : ROT_W'(y);
      end
   end

   dhfk_compose u_compose (
      .clock(clock), .reset(reset), .in_valid(v_ff[NS]), .in_ready(c_ready),
      .ctx(ctx_ff[NS]), .cs(cs), .sn(sn), .rsp(rsp));
endmodule

### rtl/dhfk_checker.sv
// port-level checker for the forward kinematics block, bound to the top level
module dhfk_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] row_index,
   input logic angle_error,
   input logic last_row
);
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && angle_error |-> last_row && row_index == 2'd0)
      else $error("error word not final");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> row_index != 2'd3) else $error("row index out of range");
   a_last_row2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !angle_error |-> last_row == (row_index == 2'd2))
      else $error("last flag mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(row_index))
      else $error("stalled word changed");
endmodule

bind dh_forward_kinematics_3r dhfk_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .row_index(rsp.data.row_index), .angle_error(rsp.data.angle_error),
   .last_row(rsp.data.last_row));
